FILE: design/eia3_pkg.sv
// shared constants and helpers for the eia3 tag accumulator
`default_nettype none
package eia3_pkg;

  localparam int WORD_W   = 32;
  localparam int BITS_W   = 6;
  localparam int LANES    = WORD_W;
  localparam int S_DATA_W = ((2 * WORD_W + BITS_W + 7) / 8) * 8;
  localparam int M_DATA_W = WORD_W;

  // bit counts above a full word count as a full word
  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] full;
    full = BITS_W'(WORD_W);
    clamp_bits = (bits > full) ? full : bits;
  endfunction

endpackage
`default_nettype wire

FILE: design/eia3_lane.sv
// one bit lane: keystream window at a fixed offset, gated by its message bit
`default_nettype none
module eia3_lane #(
  parameter int OFFSET = 0
) (
  input  wire logic [eia3_pkg::WORD_W-1:0] hi,
  input  wire logic [eia3_pkg::WORD_W-1:0] lo,
  input  wire logic                        msg_bit,
  input  wire logic [eia3_pkg::BITS_W-1:0] n,
  output logic      [eia3_pkg::WORD_W-1:0] window
);
  import eia3_pkg::*;

  logic [2*WORD_W-1:0] joined;
  logic                sel;

  always_comb begin
    joined = {hi, lo} << OFFSET;
    // data bit below the length, or the end of message window
    if (BITS_W'(OFFSET) < n) begin
      sel = msg_bit;
    end else begin
      sel = (BITS_W'(OFFSET) == n);
    end
    window = sel ? joined[2*WORD_W-1:WORD_W] : '0;
  end

endmodule
`default_nettype wire

FILE: design/eia3_merge.sv
// xor merge of all lane windows
`default_nettype none
module eia3_merge (
  input  wire logic [eia3_pkg::LANES-1:0][eia3_pkg::WORD_W-1:0] windows,
  output logic      [eia3_pkg::WORD_W-1:0]                      merged
);
  import eia3_pkg::*;

  logic [WORD_W-1:0][LANES-1:0] column;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      for (int l = 0; l < LANES; l++) begin
        column[b][l] = windows[l][b];
      end
      merged[b] = ^column[b];
    end
  end

endmodule
`default_nettype wire

FILE: design/eia3_mac_accumulator.sv
// top level: 128-eia3 tag accumulator over keystream and message words
// Takes one item per cycle, back to back. Each item carries a keystream word,
// the message word aligned with it and its valid bit count (below 32 ends the
// message); tlast marks the final keystream word. A word pair is held until the
// next keystream word arrives, then 32 bit lanes form the windows for the set
// message bits and the end of message window, and an xor merge folds them into
// the tag in the same cycle. The tag appears on the master side in the cycle
// after the item with tlast is taken; it sits in an output register, and the
// slave side stalls only in cycles where a tag waits there and m_tready is low.
`default_nettype none
module eia3_mac_accumulator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // key_word [31:0], msg_word [63:32], msg_bits [69:64], zero fill
  input  wire logic [eia3_pkg::S_DATA_W-1:0] s_tdata,
  // key_last
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // mac_tag [31:0]
  output logic      [eia3_pkg::M_DATA_W-1:0] m_tdata
);
  import eia3_pkg::*;

  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] msg_word;
  logic [BITS_W-1:0] msg_bits;

  logic [WORD_W-1:0] held_key;
  logic [WORD_W-1:0] held_msg;
  logic [BITS_W-1:0] held_bits;
  logic              have_held;
  logic              message_done;
  logic [WORD_W-1:0] tag_accum;

  logic [LANES-1:0][WORD_W-1:0] windows;
  logic [WORD_W-1:0]            merged;
  logic [WORD_W-1:0]            accum_next;
  logic                         done_next;
  logic                         active;
  logic                         accept;

  assign key_word = s_tdata[WORD_W-1:0];
  assign msg_word = s_tdata[2*WORD_W-1:WORD_W];
  assign msg_bits = s_tdata[2*WORD_W+BITS_W-1:2*WORD_W];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    eia3_lane #(
      .OFFSET(g)
    ) u_lane (
      .hi     (held_key),
      .lo     (key_word),
      .msg_bit(held_msg[WORD_W-1-g]),
      .n      (held_bits),
      .window (windows[g])
    );
  end

  eia3_merge u_merge (
    .windows(windows),
    .merged (merged)
  );

  always_comb begin
    active     = have_held && !message_done;
    accum_next = active ? (tag_accum ^ merged) : tag_accum;
    done_next  = message_done || (active && (held_bits < BITS_W'(WORD_W)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_held    <= 1'b0;
      message_done <= 1'b0;
      tag_accum    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          m_tdata      <= accum_next ^ key_word;
          have_held    <= 1'b0;
          message_done <= 1'b0;
          tag_accum    <= '0;
        end else begin
          tag_accum    <= accum_next;
          message_done <= done_next;
          have_held    <= !done_next;
          if (!done_next) begin
            held_key  <= key_word;
            held_msg  <= msg_word;
            held_bits <= clamp_bits(msg_bits);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_held_excl: assert property (@(posedge clk) disable iff (rst)
    !(have_held && message_done))
    else $error("held pair kept after message end");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    have_held |-> (held_bits <= BITS_W'(WORD_W)))
    else $error("held bit count out of range");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (!have_held && !message_done && tag_accum == '0 && m_tvalid))
    else $error("state not cleared or tag not shown after last item");
`endif

endmodule
`default_nettype wire
